// File: rtl/s2da_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package s2da_pkg;

    localparam int MAG_W       = 32;
    localparam int CMP_W       = 34;
    localparam int DIGIT_COUNT = 10;
    localparam int DIGIT_W     = 4;
    localparam int STAGE_COUNT = DIGIT_COUNT * DIGIT_W;
    localparam int CHAR_W      = 6;
    localparam int PTR_W       = 4;

    localparam logic [CHAR_W-1:0] MINUS_CODE = 6'd45;
    localparam logic [CHAR_W-1:0] ZERO_CODE  = 6'd48;

    localparam logic [PTR_W-1:0] PTR_MINUS = 4'd0;
    localparam logic [PTR_W-1:0] PTR_UNITS = 4'd10;

    localparam logic [CMP_W-1:0] PLACE_VALUE [DIGIT_COUNT] = '{
        34'd1000000000, 34'd100000000, 34'd10000000, 34'd1000000, 34'd100000,
        34'd10000, 34'd1000, 34'd100, 34'd10, 34'd1
    };

    typedef struct packed {
        logic                                neg;
        logic [MAG_W-1:0]                    mag;
        logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits;
    } dig_item_t;

endpackage
`default_nettype wire

// File: rtl/s2da_abs.sv
`timescale 1ns / 1ps
`default_nettype none
module s2da_abs
    import s2da_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [MAG_W-1:0] value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output dig_item_t             out_item
);

    logic      valid_reg;
    logic      valid_next;
    dig_item_t item_reg;
    dig_item_t item_next;
    logic      load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next       = in_ready ? in_valid : valid_reg;
        item_next.neg    = value[MAG_W-1];
        item_next.mag    = value[MAG_W-1] ? (~value + 1'b1) : value;
        item_next.digits = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// File: rtl/s2da_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module s2da_cell
    import s2da_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dig_item_t in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output dig_item_t      out_item
);

    localparam int DIGIT = STAGE / DIGIT_W;
    localparam int BIT   = DIGIT_W - 1 - (STAGE % DIGIT_W);
    localparam logic [CMP_W-1:0] STEP = PLACE_VALUE[DIGIT] << BIT;

    logic             valid_reg;
    logic             valid_next;
    dig_item_t        item_reg;
    dig_item_t        item_next;
    logic             load;
    logic [CMP_W-1:0] mag_ext;
    logic [CMP_W-1:0] diff;
    logic             fits;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign mag_ext  = {{(CMP_W-MAG_W){1'b0}}, in_item.mag};
    assign diff     = mag_ext - STEP;
    assign fits     = mag_ext >= STEP;

    // one restoring step of the digit for this place
    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        item_next  = in_item;
        if (fits)
        begin
            item_next.mag              = diff[MAG_W-1:0];
            item_next.digits[DIGIT][BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// File: rtl/s2da_ser.sv
`timescale 1ns / 1ps
`default_nettype none
module s2da_ser
    import s2da_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dig_item_t in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [CHAR_W-1:0] char_code,
    output logic           last_char
);

    logic                                busy_reg;
    logic                                busy_next;
    logic [PTR_W-1:0]                    ptr_reg;
    logic [PTR_W-1:0]                    ptr_next;
    logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits_reg;
    logic [PTR_W-1:0]                    first_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [CHAR_W-1:0]                   char_reg;
    logic [CHAR_W-1:0]                   char_next;
    logic                                last_reg;
    logic                                last_next;
    logic                                emit;
    logic                                last_emit;
    logic                                load;
    logic [PTR_W-1:0]                    lead;
    logic [PTR_W-1:0]                    first_ptr;
    logic [PTR_W-1:0]                    start_ptr;
    logic [PTR_W-1:0]                    digit_sel;

    assign emit      = busy_reg && (!out_valid_reg || out_ready);
    assign last_emit = emit && (ptr_reg == PTR_UNITS);
    assign in_ready  = !busy_reg || last_emit;
    assign load      = in_valid && in_ready;

    // first nonzero digit, units place if all zero
    always_comb
    begin
        lead = PTR_W'(DIGIT_COUNT - 1);
        for (int i = DIGIT_COUNT - 1; i >= 0; i--)
        begin
            if (in_item.digits[i] != '0)
            begin
                lead = PTR_W'(i);
            end
        end
        first_ptr = lead + 1'b1;
        start_ptr = in_item.neg ? PTR_MINUS : first_ptr;
    end

    assign digit_sel = (ptr_reg == PTR_MINUS) ? '0 : (ptr_reg - 1'b1);

    always_comb
    begin
        busy_next = busy_reg;
        ptr_next  = ptr_reg;
        if (load)
        begin
            busy_next = 1'b1;
            ptr_next  = start_ptr;
        end
        else if (emit)
        begin
            busy_next = !last_emit;
            // after the minus sign, skip the leading zeros
            ptr_next  = (ptr_reg == PTR_MINUS) ? first_reg : (ptr_reg + 1'b1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = (ptr_reg == PTR_MINUS) ? MINUS_CODE
                           : (ZERO_CODE + {2'b00, digits_reg[digit_sel]});
            last_next      = (ptr_reg == PTR_UNITS);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            ptr_reg       <= PTR_MINUS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digits_reg <= in_item.digits;
            first_reg  <= first_ptr;
        end
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule
`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   signals                        role
// input     in_valid, in_ready, value      one signed 32-bit number per request
// output    out_valid, out_ready,          one ascii character per request,
//           char_code, last_char           last_char on the final one
//
// a number leaves as 1 to 11 characters, one per cycle while out_ready is high;
// the one-character output port limits how fast numbers go through
// the path to the first character is the absolute value stage, a chain
// of 40 compare-subtract cells (four per decimal place), then the serializer
// reset clears only the valid and busy flags and the character pointer
// a stalled output holds the serializer; full stages behind it hold, empty ones still fill
module signed_int_to_decimal_ascii_unit
    import s2da_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [MAG_W-1:0]  value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CHAR_W-1:0]      char_code,
    output logic                   last_char
);

    logic      chain_valid [STAGE_COUNT+1];
    logic      chain_ready [STAGE_COUNT+1];
    dig_item_t chain_item  [STAGE_COUNT+1];

    s2da_abs u_abs (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    for (genvar s = 0; s < STAGE_COUNT; s++)
    begin : g_cell
        s2da_cell #(
            .STAGE (s)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[s]),
            .in_ready  (chain_ready[s]),
            .in_item   (chain_item[s]),
            .out_valid (chain_valid[s+1]),
            .out_ready (chain_ready[s+1]),
            .out_item  (chain_item[s+1])
        );
    end

    s2da_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[STAGE_COUNT]),
        .in_ready  (chain_ready[STAGE_COUNT]),
        .in_item   (chain_item[STAGE_COUNT]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb_signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
module tb_signed_int_to_decimal_ascii_unit;
    import s2da_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int PIPE_LATENCY = 42;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_COUNT = 100;
    localparam int QUIET_TAIL   = 20;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } ascii_char_t;

    class decimal_text_board;
        ascii_char_t pending_chars[$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        // spell the accepted number as ascii and queue the characters
        function void note_number(logic [MAG_W-1:0] number);
            ascii_char_t      text[$];
            ascii_char_t      ch;
            logic [MAG_W-1:0] mag;
            logic [MAG_W-1:0] place;
            logic [MAG_W-1:0] digit;
            bit               started;
            started = 0;
            mag = number[MAG_W-1] ? (32'd0 - number) : number;
            place = 32'd1000000000;
            if (number[MAG_W-1])
            begin
                ch.code = MINUS_CODE;
                ch.last = 1'b0;
                text.push_back(ch);
            end
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                digit = mag / place;
                mag = mag % place;
                if (digit != 0)
                    started = 1;
                if (started || i == DIGIT_COUNT - 1)
                begin
                    ch.code = ZERO_CODE + digit[CHAR_W-1:0];
                    ch.last = 1'b0;
                    text.push_back(ch);
                end
                place = place / 10;
            end
            text[text.size() - 1].last = 1'b1;
            foreach (text[k])
                pending_chars.push_back(text[k]);
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic last);
            ascii_char_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character code=%0d last=%0b", $time, code, last);
                mismatch_count++;
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code)
            begin
                $display("%0t: char_code expected %0d actual %0d", $time, want.code, code);
                mismatch_count++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_char expected %0b actual %0b", $time, want.last, last);
                mismatch_count++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [MAG_W-1:0]  value;
    logic              out_valid;
    logic              out_ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    decimal_text_board board = new();
    bit                send_idle_on;
    bit                sink_stall_on;
    int                cycle_count;

    signed_int_to_decimal_ascii_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last_char (last_char)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_char(char_code, last_char);
    end

    // output stall bursts of random length, while sink_stall_on is set
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (sink_stall_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_number(input logic [MAG_W-1:0] number);
        if (send_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= number;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_number(number);
    endtask

    function automatic logic [MAG_W-1:0] pick_number();
        logic [MAG_W-1:0] lo;
        logic [MAG_W-1:0] hi;
        logic [MAG_W-1:0] number;
        int               len;
        int               mode;
        mode = $urandom_range(0, 19);
        if (mode < 2)
            return $urandom;
        if (mode == 2)
        begin
            number = 32'd1;
            repeat ($urandom_range(0, 9)) number = number * 10;
            number = number - $urandom_range(0, 1);
            return $urandom_range(0, 1) ? (32'd0 - number) : number;
        end
        if (mode == 3)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        len = $urandom_range(1, DIGIT_COUNT);
        lo = 32'd1;
        repeat (len - 1) lo = lo * 10;
        hi = (len == DIGIT_COUNT) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (len == 1)
            lo = 32'd0;
        number = $urandom_range(hi, lo);
        return $urandom_range(0, 1) ? (32'd0 - number) : number;
    endfunction

    initial
    begin
        logic [MAG_W-1:0] directed[$];
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
                     -32'sd999999999, -32'sd1000000000, 32'd100, 32'd1000000,
                     -32'sd7, 32'd5, 32'h0000_FFFF, 32'hFFFF_0000, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'd1234567890, -32'sd2147483647};
        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        send_idle_on = 1'b0;
        sink_stall_on = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_number(directed[i]);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n % 25 == 0)
            begin
                send_idle_on = (n < RANDOM_COUNT - QUIET_TAIL) && ((n / 25) % 3 != 2);
                sink_stall_on = (n < RANDOM_COUNT - QUIET_TAIL) && ((n / 25) % 3 != 1);
            end
            if (n >= RANDOM_COUNT - QUIET_TAIL)
            begin
                send_idle_on = 1'b0;
                sink_stall_on = 1'b0;
            end
            if (n == RANDOM_COUNT / 2)
            begin
                in_valid <= 1'b0;
                while (board.pending() != 0)
                    @(posedge clk);
            end
            send_number(pick_number());
        end
        in_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
